[rtl/cds_pkg.sv]
// Package for the calendar date stepper: date struct, command and status codes,
// calendar tables and small arithmetic helpers. No dependencies.
package cds_pkg;

   typedef enum logic [2:0] {
      CMD_LOAD       = 3'd0,
      CMD_NEXT_DAY   = 3'd1,
      CMD_PREV_DAY   = 3'd2,
      CMD_NEXT_MONTH = 3'd3,
      CMD_PREV_MONTH = 3'd4,
      CMD_NEXT_YEAR  = 3'd5,
      CMD_PREV_YEAR  = 3'd6,
      CMD_READ       = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_YEAR   = 3'd1,
      ST_BAD_MONTH  = 3'd2,
      ST_BAD_DAY    = 3'd3,
      ST_STEP_RANGE = 3'd4
   } status_type;

   // Year is kept along with its century and year-of-century.
   typedef struct packed {
      logic [13:0] year;
      logic [7:0]  cent;
      logic [6:0]  yy;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   localparam logic [13:0] YEAR_LO_RST = 14'd1753;
   localparam logic [13:0] YEAR_HI_RST = 14'd9999;
   localparam date_type    DATE_RST     = '{year: 14'd1753, cent: 8'd17, yy: 7'd53,
                                            month: 4'd1, day: 5'd1};

   localparam logic REG_YEAR_LO = 1'b0;
   localparam logic REG_YEAR_HI = 1'b1;

   localparam logic [6:0] YY_LAST  = 7'd99;
   localparam logic [3:0] MONTH_LAST = 4'd12;
   localparam logic [4:0] DAY_FEB_LEAP = 5'd29;

   function automatic logic is_leap(input logic [7:0] cent, input logic [6:0] yy);
      is_leap = (yy != 7'd0) ? (yy[1:0] == 2'b00) : (cent[1:0] == 2'b00);
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      case (month)
         4'd2:    days_in = leap ? 5'd29 : 5'd28;
         4'd4:    days_in = 5'd30;
         4'd6:    days_in = 5'd30;
         4'd9:    days_in = 5'd30;
         4'd11:   days_in = 5'd30;
         default: days_in = 5'd31;
      endcase
   endfunction

   function automatic logic [2:0] century_code(input logic [2:0] idx);
      case (idx)
         3'd0, 3'd4: century_code = 3'd4;
         3'd1, 3'd5: century_code = 3'd2;
         3'd2, 3'd6: century_code = 3'd0;
         default:    century_code = 3'd6;
      endcase
   endfunction

   function automatic logic [2:0] month_code(input logic [3:0] month, input logic leap);
      case (month)
         4'd1:    month_code = leap ? 3'd6 : 3'd0;
         4'd2:    month_code = leap ? 3'd2 : 3'd3;
         4'd3:    month_code = 3'd3;
         4'd4:    month_code = 3'd6;
         4'd5:    month_code = 3'd1;
         4'd6:    month_code = 3'd4;
         4'd7:    month_code = 3'd6;
         4'd8:    month_code = 3'd2;
         4'd9:    month_code = 3'd5;
         4'd10:   month_code = 3'd0;
         4'd11:   month_code = 3'd3;
         4'd12:   month_code = 3'd5;
         default: month_code = 3'd0;
      endcase
   endfunction

   // Remainder by 7 for values below 209: quotient by reciprocal 147/1024.
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [15:0] prod;
      logic [7:0]  rem;
      prod = x * 8'd147;
      rem  = x - 8'(prod[15:10] * 3'd7);
      mod7 = rem[2:0];
   endfunction

endpackage

[rtl/cds_year_split.sv]
// Splits a load year into century and year-of-century by reciprocal multiply.
// Depends on nothing but its ports.
module cds_year_split (
   input  logic [13:0] year,
   output logic [7:0]  cent,
   output logic [6:0]  yy
);

   logic [26:0] prod;
   logic [13:0] rem;

   // floor(year / 100) is exact for all 14-bit years with 5243 / 2^19.
   assign prod = year * 13'd5243;
   assign cent = prod[26:19];
   assign rem  = year - 14'(cent * 7'd100);
   assign yy   = rem[6:0];

endmodule

[rtl/cds_date_next.sv]
// Next-date and status logic for one command of the calendar date stepper.
// Depends on cds_pkg.
module cds_date_next (
   input  cds_pkg::date_type   cur,
   input  cds_pkg::cmd_type    cmd,
   input  logic [13:0]         new_year,
   input  logic [7:0]          new_cent,
   input  logic [6:0]          new_yy,
   input  logic [3:0]          new_month,
   input  logic [4:0]          new_day,
   input  logic [13:0]         year_lo,
   input  logic [13:0]         year_hi,
   output cds_pkg::date_type   nxt,
   output cds_pkg::status_type status
);

   logic               leap_cur;
   logic               leap_up;
   logic               leap_dn;
   logic               leap_new;
   logic [14:0]        yr_up;
   logic [13:0]        yr_dn;
   logic               up_ok;
   logic               dn_ok;
   logic [7:0]         cent_up;
   logic [6:0]         yy_up;
   logic [7:0]         cent_dn;
   logic [6:0]         yy_dn;
   logic [4:0]         lim;
   logic               changed;
   logic               yr_ok;
   cds_pkg::date_type  cand;
   cds_pkg::status_type st;

   assign yr_up   = {1'b0, cur.year} + 15'd1;
   assign yr_dn   = cur.year - 14'd1;
   assign up_ok   = (yr_up >= {1'b0, year_lo}) && (yr_up <= {1'b0, year_hi});
   assign dn_ok   = (cur.year != 14'd0) && (yr_dn >= year_lo) && (yr_dn <= year_hi);
   assign cent_up = (cur.yy == cds_pkg::YY_LAST) ? cur.cent + 8'd1 : cur.cent;
   assign yy_up   = (cur.yy == cds_pkg::YY_LAST) ? 7'd0 : cur.yy + 7'd1;
   assign cent_dn = (cur.yy == 7'd0) ? cur.cent - 8'd1 : cur.cent;
   assign yy_dn   = (cur.yy == 7'd0) ? cds_pkg::YY_LAST : cur.yy - 7'd1;

   assign leap_cur = cds_pkg::is_leap(cur.cent, cur.yy);
   assign leap_up  = cds_pkg::is_leap(cent_up, yy_up);
   assign leap_dn  = cds_pkg::is_leap(cent_dn, yy_dn);
   assign leap_new = cds_pkg::is_leap(new_cent, new_yy);

   always_comb begin
      cand    = cur;
      st      = cds_pkg::ST_OK;
      changed = 1'b0;
      yr_ok   = 1'b1;
      lim     = 5'd31;
      case (cmd)
         cds_pkg::CMD_LOAD: begin
            if (new_year < year_lo || new_year > year_hi) begin
               st = cds_pkg::ST_BAD_YEAR;
            end else if (new_month == 4'd0 || new_month > cds_pkg::MONTH_LAST) begin
               st = cds_pkg::ST_BAD_MONTH;
            end else if (new_day == 5'd0 ||
                         new_day > cds_pkg::days_in(new_month, leap_new)) begin
               st = cds_pkg::ST_BAD_DAY;
            end else begin
               cand = '{year: new_year, cent: new_cent, yy: new_yy,
                        month: new_month, day: new_day};
            end
         end
         cds_pkg::CMD_NEXT_DAY: begin
            if (cur.day >= cds_pkg::days_in(cur.month, leap_cur)) begin
               cand.day = 5'd1;
               if (cur.month == cds_pkg::MONTH_LAST) begin
                  cand.month = 4'd1;
                  cand.year  = yr_up[13:0];
                  cand.cent  = cent_up;
                  cand.yy    = yy_up;
                  changed    = 1'b1;
                  yr_ok      = up_ok;
               end else begin
                  cand.month = cur.month + 4'd1;
               end
            end else begin
               cand.day = cur.day + 5'd1;
            end
         end
         cds_pkg::CMD_PREV_DAY: begin
            if (cur.day <= 5'd1) begin
               if (cur.month <= 4'd1) begin
                  cand.month = cds_pkg::MONTH_LAST;
                  cand.day   = 5'd31;
                  cand.year  = yr_dn;
                  cand.cent  = cent_dn;
                  cand.yy    = yy_dn;
                  changed    = 1'b1;
                  yr_ok      = dn_ok;
               end else begin
                  cand.month = cur.month - 4'd1;
                  cand.day   = cds_pkg::days_in(cur.month - 4'd1, leap_cur);
               end
            end else begin
               cand.day = cur.day - 5'd1;
            end
         end
         cds_pkg::CMD_NEXT_MONTH: begin
            if (cur.month >= cds_pkg::MONTH_LAST) begin
               cand.month = 4'd1;
               cand.year  = yr_up[13:0];
               cand.cent  = cent_up;
               cand.yy    = yy_up;
               changed    = 1'b1;
               yr_ok      = up_ok;
            end else begin
               cand.month = cur.month + 4'd1;
               lim        = cds_pkg::days_in(cur.month + 4'd1, leap_cur);
               if (cur.day > lim) begin
                  cand.day = lim;
               end
            end
         end
         cds_pkg::CMD_PREV_MONTH: begin
            if (cur.month <= 4'd1) begin
               cand.month = cds_pkg::MONTH_LAST;
               cand.year  = yr_dn;
               cand.cent  = cent_dn;
               cand.yy    = yy_dn;
               changed    = 1'b1;
               yr_ok      = dn_ok;
            end else begin
               cand.month = cur.month - 4'd1;
               lim        = cds_pkg::days_in(cur.month - 4'd1, leap_cur);
               if (cur.day > lim) begin
                  cand.day = lim;
               end
            end
         end
         cds_pkg::CMD_NEXT_YEAR: begin
            cand.year = yr_up[13:0];
            cand.cent = cent_up;
            cand.yy   = yy_up;
            changed   = 1'b1;
            yr_ok     = up_ok;
            if (cur.month == 4'd2 && cur.day == cds_pkg::DAY_FEB_LEAP && !leap_up) begin
               cand.day = 5'd28;
            end
         end
         cds_pkg::CMD_PREV_YEAR: begin
            cand.year = yr_dn;
            cand.cent = cent_dn;
            cand.yy   = yy_dn;
            changed   = 1'b1;
            yr_ok     = dn_ok;
            if (cur.month == 4'd2 && cur.day == cds_pkg::DAY_FEB_LEAP && !leap_dn) begin
               cand.day = 5'd28;
            end
         end
         default: begin
            cand = cur;
         end
      endcase
   end

   always_comb begin
      if (changed && !yr_ok) begin
         status = cds_pkg::ST_STEP_RANGE;
         nxt    = cur;
      end else if (st != cds_pkg::ST_OK) begin
         status = st;
         nxt    = cur;
      end else begin
         status = cds_pkg::ST_OK;
         nxt    = cand;
      end
   end

endmodule

[rtl/cds_weekday.sv]
// Weekday of a date by the century and month table method.
// Depends on cds_pkg.
module cds_weekday (
   input  cds_pkg::date_type date,
   output logic [2:0]        weekday
);

   logic       leap;
   logic [2:0] cc;
   logic [2:0] mc;
   logic [7:0] sum;

   assign leap    = cds_pkg::is_leap(date.cent, date.yy);
   assign cc      = cds_pkg::century_code(date.cent[2:0] + 3'd7);
   assign mc      = cds_pkg::month_code(date.month, leap);
   assign sum     = {5'd0, cc} + {1'b0, date.yy} + {3'd0, date.yy[6:2]}
                  + {3'd0, date.day} + {5'd0, mc};
   assign weekday = cds_pkg::mod7(sum);

endmodule

[rtl/calendar_date_stepper_top.sv]
// Top level of the Gregorian calendar date stepper with weekday output.
// Depends on cds_pkg, cds_year_split, cds_date_next and cds_weekday.
//
// Usage:
//   req channel: one beat is one command (load, step day/month/year forward
//   or back, read) with the load date fields. rsp channel: one beat per
//   command with the date after it, its weekday and a status.
//   csr port: APB-style, lower year limit at 0x0 and upper year limit at
//   0x4; write only while no command is in flight.
//   Path: an accepted command waits in the input register and moves into
//   the result register once that is empty or rsp is not stalled, and
//   rsp_valid rises with it. Throughput: one command per cycle while rsp is
//   not stalled; the input register and the result register are each one
//   stage, and the held date updates as a command moves into the result register.
//   Stall: while rsp_stall holds a result, the command waiting in the input
//   register stays there and req_stall rises; the result payload holds.
//   Reset: date becomes 1753-01-01, year limits 1753..9999, both stages
//   empty.
module calendar_date_stepper_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [13:0] req_new_year,
   input  logic [3:0]  req_new_month,
   input  logic [4:0]  req_new_day,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_cur_year,
   output logic [3:0]  rsp_cur_month,
   output logic [4:0]  rsp_cur_day,
   output logic [2:0]  rsp_weekday,
   output logic [2:0]  rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                s1_valid_ff;
   cds_pkg::cmd_type    cmd_ff;
   logic [13:0]         ny_ff;
   logic [7:0]          nyc_ff;
   logic [6:0]          nyy_ff;
   logic [3:0]          nm_ff;
   logic [4:0]          nd_ff;
   logic [7:0]          nyc_in;
   logic [6:0]          nyy_in;

   logic                out_valid_ff;
   cds_pkg::date_type   out_date_ff;
   cds_pkg::status_type out_status_ff;

   cds_pkg::date_type   date_ff;
   cds_pkg::date_type   date_in;
   cds_pkg::status_type status_in;
   logic [13:0]         year_lo_ff;
   logic [13:0]         year_hi_ff;

   logic                req_take;
   logic                advance;
   logic                csr_write;

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   cds_year_split u_split (
      .year (req_new_year),
      .cent (nyc_in),
      .yy   (nyy_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (req_take) begin
         cmd_ff <= cds_pkg::cmd_type'(req_cmd);
         ny_ff  <= req_new_year;
         nyc_ff <= nyc_in;
         nyy_ff <= nyy_in;
         nm_ff  <= req_new_month;
         nd_ff  <= req_new_day;
      end
   end

   cds_date_next u_next (
      .cur       (date_ff),
      .cmd       (cmd_ff),
      .new_year  (ny_ff),
      .new_cent  (nyc_ff),
      .new_yy    (nyy_ff),
      .new_month (nm_ff),
      .new_day   (nd_ff),
      .year_lo   (year_lo_ff),
      .year_hi   (year_hi_ff),
      .nxt       (date_in),
      .status    (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         date_ff      <= cds_pkg::DATE_RST;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            date_ff      <= date_in;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_date_ff   <= date_in;
         out_status_ff <= status_in;
      end
   end

   cds_weekday u_weekday (
      .date    (out_date_ff),
      .weekday (rsp_weekday)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_cur_year  = out_date_ff.year;
   assign rsp_cur_month = out_date_ff.month;
   assign rsp_cur_day   = out_date_ff.day;
   assign rsp_status    = out_status_ff;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         year_lo_ff <= cds_pkg::YEAR_LO_RST;
         year_hi_ff <= cds_pkg::YEAR_HI_RST;
      end else if (csr_write) begin
         if (csr_paddr[2] == cds_pkg::REG_YEAR_LO) begin
            year_lo_ff <= csr_pwdata[13:0];
         end else begin
            year_hi_ff <= csr_pwdata[13:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == cds_pkg::REG_YEAR_HI) ? {18'd0, year_hi_ff}
                                                                : {18'd0, year_lo_ff};

endmodule

[rtl/cds_checker.sv]
// Port-level checks for the calendar date stepper, bound to its top level.
// Depends on cds_pkg and calendar_date_stepper_top.
module cds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [13:0] rsp_cur_year,
   input logic [3:0]  rsp_cur_month,
   input logic [4:0]  rsp_cur_day,
   input logic [2:0]  rsp_weekday,
   input logic [2:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cur_year)
         && $stable(rsp_cur_month) && $stable(rsp_cur_day)
         && $stable(rsp_weekday) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("command stalled with result side free");

   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cur_month != 4'd0 && rsp_cur_month <= cds_pkg::MONTH_LAST
         && rsp_cur_day != 5'd0
         && (rsp_cur_month != 4'd2 || rsp_cur_day <= cds_pkg::DAY_FEB_LEAP))
      else $error("result date out of calendar");

endmodule

bind calendar_date_stepper_top cds_checker u_cds_checker (.*);

[dv/calendar_date_stepper_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for calendar_date_stepper_top: a queue-fed command driver,
// a result monitor with an in-bench date predictor, and APB limit writes. Uses cds_pkg.
module calendar_date_stepper_top_tb;

   typedef struct {
      cds_pkg::cmd_type cmd;
      logic [13:0]      new_year;
      logic [3:0]       new_month;
      logic [4:0]       new_day;
   } cal_cmd_type;

   typedef struct {
      int                  year;
      int                  month;
      int                  day;
      int                  weekday;
      cds_pkg::status_type status;
   } date_result_type;

   localparam int CENTURY_TAB[8]     = '{4, 2, 0, 6, 4, 2, 0, 6};
   localparam int MONTH_TAB[12]      = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
   localparam int MONTH_TAB_LEAP[12] = '{6, 2, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
   localparam int MAX_GAP            = 13;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = cds_pkg::CMD_READ;
   logic [13:0] req_new_year = '0;
   logic [3:0]  req_new_month = '0;
   logic [4:0]  req_new_day = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [13:0] rsp_cur_year;
   logic [3:0]  rsp_cur_month;
   logic [4:0]  rsp_cur_day;
   logic [2:0]  rsp_weekday;
   logic [2:0]  rsp_status;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   calendar_date_stepper_top dut (.*);

   cal_cmd_type     cmd_queue[$];
   date_result_type expected_dates[$];

   int held_year = cds_pkg::YEAR_LO_RST;
   int held_month = 1;
   int held_day = 1;
   int year_lo = cds_pkg::YEAR_LO_RST;
   int year_hi = cds_pkg::YEAR_HI_RST;

   int fail_count = 0;
   int commands_seen = 0;
   int results_seen = 0;
   int steps_refused = 0;
   int loads_rejected = 0;
   int settings_count = 0;

   bit req_beat_done = 1'b0;
   bit rsp_beat_done = 1'b0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int req_gap_left = 0;
   int rsp_hold_left = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int month_days(int y, int m);
      case (m)
         2:             return leap_year(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic int weekday_for(int y, int m, int d);
      int yy;
      int sum;
      yy  = y % 100;
      sum = CENTURY_TAB[(y / 100 + 7) & 7] + yy + yy / 4 + d;
      sum += leap_year(y) ? MONTH_TAB_LEAP[m - 1] : MONTH_TAB[m - 1];
      return sum % 7;
   endfunction

   function automatic bit year_in_range(int y);
      return y >= year_lo && y <= year_hi;
   endfunction

   // Apply one command to the held date and return the beat it should produce.
   function automatic date_result_type advance_date(cal_cmd_type c);
      date_result_type r;
      int y;
      int m;
      int d;
      bit changed;
      cds_pkg::status_type st;
      y = held_year;
      m = held_month;
      d = held_day;
      changed = 1'b0;
      st = cds_pkg::ST_OK;
      case (c.cmd)
         cds_pkg::CMD_LOAD: begin
            if (!year_in_range(c.new_year)) st = cds_pkg::ST_BAD_YEAR;
            else if (c.new_month < 1 || c.new_month > 12) st = cds_pkg::ST_BAD_MONTH;
            else if (c.new_day < 1 || c.new_day > month_days(c.new_year, c.new_month))
               st = cds_pkg::ST_BAD_DAY;
            else begin
               y = c.new_year;
               m = c.new_month;
               d = c.new_day;
            end
         end
         cds_pkg::CMD_NEXT_DAY: begin
            d++;
            if (d > month_days(y, m)) begin
               d = 1;
               m++;
               if (m > 12) begin
                  m = 1;
                  y++;
                  changed = 1'b1;
               end
            end
         end
         cds_pkg::CMD_PREV_DAY: begin
            d--;
            if (d < 1) begin
               m--;
               if (m < 1) begin
                  m = 12;
                  y--;
                  changed = 1'b1;
               end
               d = (y >= 0) ? month_days(y, m) : 31;
            end
         end
         cds_pkg::CMD_NEXT_MONTH, cds_pkg::CMD_PREV_MONTH: begin
            if (c.cmd == cds_pkg::CMD_NEXT_MONTH) begin
               m++;
               if (m > 12) begin
                  m = 1;
                  y++;
                  changed = 1'b1;
               end
            end else begin
               m--;
               if (m < 1) begin
                  m = 12;
                  y--;
                  changed = 1'b1;
               end
            end
            if (y >= 0 && d > month_days(y, m)) d = month_days(y, m);
         end
         cds_pkg::CMD_NEXT_YEAR, cds_pkg::CMD_PREV_YEAR: begin
            y += (c.cmd == cds_pkg::CMD_NEXT_YEAR) ? 1 : -1;
            changed = 1'b1;
            if (y >= 0 && m == 2 && d == 29 && !leap_year(y)) d = 28;
         end
         default: ;
      endcase
      if (changed && !year_in_range(y)) begin
         st = cds_pkg::ST_STEP_RANGE;
         steps_refused++;
      end else if (st == cds_pkg::ST_OK) begin
         held_year  = y & 14'h3fff;
         held_month = m & 4'hf;
         held_day   = d & 5'h1f;
      end else begin
         loads_rejected++;
      end
      r.year    = held_year;
      r.month   = held_month;
      r.day     = held_day;
      r.weekday = weekday_for(held_year, held_month, held_day);
      r.status  = st;
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Command driver: hold a stalled beat, otherwise idle out the gap and send the next one.
   always @(negedge clock) begin : cmd_driver
      cal_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_done) begin
         req_beat_done = 1'b0;
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            c = cmd_queue.pop_front();
            req_valid     <= 1'b1;
            req_cmd       <= c.cmd;
            req_new_year  <= c.new_year;
            req_new_month <= c.new_month;
            req_new_day   <= c.new_day;
            req_gap_left = req_burst ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: draw a fresh stall length after each taken beat.
   always @(negedge clock) begin : rsp_receiver
      if (rsp_beat_done) begin
         rsp_beat_done = 1'b0;
         rsp_hold_left = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : beat_monitor
      date_result_type want;
      cal_cmd_type c;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_beat_done = 1'b1;
            results_seen++;
            if (expected_dates.size() == 0) begin
               $error("result beat with no command outstanding");
               fail_count++;
            end else begin
               want = expected_dates.pop_front();
               check_field("cur_year", want.year, rsp_cur_year);
               check_field("cur_month", want.month, rsp_cur_month);
               check_field("cur_day", want.day, rsp_cur_day);
               check_field("weekday", want.weekday, rsp_weekday);
               check_field("status", want.status, rsp_status);
            end
         end
         if (req_valid && !req_stall) begin
            req_beat_done = 1'b1;
            commands_seen++;
            c.cmd       = cds_pkg::cmd_type'(req_cmd);
            c.new_year  = req_new_year;
            c.new_month = req_new_month;
            c.new_day   = req_new_day;
            expected_dates.push_back(advance_date(c));
         end
      end
   end

   task automatic push_cmd(cds_pkg::cmd_type cmd, int y, int m, int d);
      cal_cmd_type c;
      c.cmd       = cmd;
      c.new_year  = 14'(y);
      c.new_month = 4'(m);
      c.new_day   = 5'(d);
      cmd_queue.push_back(c);
   endtask

   // Mostly steps and reads, mixed with well-formed loads near month ends and limits and noise loads.
   task automatic queue_random_commands(int count);
      cal_cmd_type c;
      int pick;
      int y;
      int len;
      for (int i = 0; i < count; i++) begin
         pick        = $urandom_range(0, 99);
         c.new_year  = 14'($urandom);
         c.new_month = 4'($urandom);
         c.new_day   = 5'($urandom);
         if (pick < 5) begin
            c.cmd = cds_pkg::CMD_LOAD;
         end else if (pick < 30) begin
            c.cmd = cds_pkg::CMD_LOAD;
            case ($urandom_range(0, 3))
               0:       y = year_lo - 1 + $urandom_range(0, 2);
               1:       y = year_hi - 1 + $urandom_range(0, 2);
               2:       y = (year_lo <= year_hi) ? year_lo + $urandom_range(0, year_hi - year_lo)
                                                 : $urandom_range(1, 9999);
               default: y = $urandom_range(1, 9999);
            endcase
            if (y < 0) y = 0;
            c.new_year  = 14'(y);
            c.new_month = 4'($urandom_range(1, 12));
            len = month_days(y, c.new_month);
            case ($urandom_range(0, 3))
               0:       c.new_day = 5'd1;
               1:       c.new_day = 5'(len);
               2:       c.new_day = 5'(len - 1);
               default: c.new_day = 5'($urandom_range(1, len));
            endcase
         end else begin
            c.cmd = cds_pkg::cmd_type'($urandom_range(1, 7));
         end
         cmd_queue.push_back(c);
      end
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (cmd_queue.size() != 0 || req_valid || expected_dates.size() != 0);
      repeat (4) @(posedge clock);
      #1;
   endtask

   task automatic csr_write(logic sel, int value);
      logic [31:0] seen;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {18'($urandom), 14'(value)};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == cds_pkg::REG_YEAR_LO) year_lo = value;
      else year_hi = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      check_field("csr readback", value, seen[13:0]);
   endtask

   task automatic set_limits(int lo, int hi);
      csr_write(cds_pkg::REG_YEAR_LO, lo);
      csr_write(cds_pkg::REG_YEAR_HI, hi);
      settings_count++;
      @(posedge clock);
      #1;
   endtask

   initial begin : stimulus
      int lo;
      int hi;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // Reset limits 1753..9999, date 1753-01-01.
      push_cmd(cds_pkg::CMD_READ, 0, 0, 0);
      push_cmd(cds_pkg::CMD_PREV_DAY, 0, 0, 0);
      push_cmd(cds_pkg::CMD_PREV_MONTH, 0, 0, 0);
      push_cmd(cds_pkg::CMD_PREV_YEAR, 0, 0, 0);
      push_cmd(cds_pkg::CMD_NEXT_DAY, 0, 0, 0);
      push_cmd(cds_pkg::CMD_LOAD, 0, 1, 1);
      push_cmd(cds_pkg::CMD_LOAD, 16383, 15, 31);
      push_cmd(cds_pkg::CMD_LOAD, 2000, 0, 1);
      push_cmd(cds_pkg::CMD_LOAD, 2000, 13, 1);
      push_cmd(cds_pkg::CMD_LOAD, 2000, 2, 30);
      push_cmd(cds_pkg::CMD_LOAD, 2000, 4, 0);
      push_cmd(cds_pkg::CMD_LOAD, 1900, 2, 29);
      push_cmd(cds_pkg::CMD_LOAD, 2000, 2, 29);
      push_cmd(cds_pkg::CMD_NEXT_YEAR, 0, 0, 0);
      push_cmd(cds_pkg::CMD_LOAD, 2024, 1, 31);
      push_cmd(cds_pkg::CMD_NEXT_MONTH, 0, 0, 0);
      push_cmd(cds_pkg::CMD_PREV_MONTH, 0, 0, 0);
      push_cmd(cds_pkg::CMD_LOAD, 2100, 3, 1);
      push_cmd(cds_pkg::CMD_PREV_DAY, 0, 0, 0);
      push_cmd(cds_pkg::CMD_LOAD, 1999, 12, 31);
      push_cmd(cds_pkg::CMD_NEXT_DAY, 0, 0, 0);
      push_cmd(cds_pkg::CMD_LOAD, 9999, 12, 31);
      push_cmd(cds_pkg::CMD_NEXT_DAY, 0, 0, 0);
      push_cmd(cds_pkg::CMD_NEXT_MONTH, 0, 0, 0);
      push_cmd(cds_pkg::CMD_NEXT_YEAR, 0, 0, 0);
      push_cmd(cds_pkg::CMD_READ, 16383, 15, 31);
      queue_random_commands(200);
      wait_drained();

      set_limits(1, 9999);
      queue_random_commands(250);
      wait_drained();

      // Narrow window: the held date may start outside it.
      set_limits(2000, 2001);
      queue_random_commands(200);
      wait_drained();

      // Crossed limits: every load and every year change is refused.
      set_limits(5000, 4000);
      queue_random_commands(100);
      wait_drained();

      set_limits(9999, 9999);
      queue_random_commands(100);
      wait_drained();

      set_limits(1, 1);
      queue_random_commands(100);
      wait_drained();

      for (int k = 0; k < 3; k++) begin
         lo = $urandom_range(1, 9999);
         hi = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9999) : $urandom_range(lo, 9999);
         set_limits(lo, hi);
         queue_random_commands(80);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      #1;
      if (expected_dates.size() != 0) begin
         $error("%0d expected results never arrived", expected_dates.size());
         fail_count++;
      end
      $display("Ran %0d commands (%0d results) over %0d limit settings after reset defaults;",
               commands_seen, results_seen, settings_count);
      $display("%0d steps refused at the year limits, %0d loads rejected.",
               steps_refused, loads_rejected);
      if (fail_count == 0) begin
         $display("[calendar_date_stepper_top] OK");
      end else begin
         $display("[calendar_date_stepper_top] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("[calendar_date_stepper_top] ERROR");
      $finish;
   end

endmodule
